// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mmhs_pkg.sv =====
package mmhs_pkg;

   localparam int IDX_W        = 10;
   localparam int MAX_ELEMENTS = 1 << IDX_W;
   localparam int CNT_W        = IDX_W + 1;
   localparam int VAL_W        = 32;
   localparam int META_W       = IDX_W + 1;
   localparam int KIND_W       = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 2;

   localparam logic [CNT_W-1:0]      COUNT_RESET   = CNT_W'(MAX_ELEMENTS);
   localparam logic [CSR_ADDR_W-1:0] ADDR_ELEM_CNT = '0;

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_LOAD    = 2'd0;
   localparam kind_type KIND_MERGE   = 2'd1;
   localparam kind_type KIND_EXTRACT = 2'd2;

   // one table entry's bookkeeping: removed flag above the set label
   typedef struct packed {
      logic             removed;
      logic [IDX_W-1:0] label;
   } meta_type;

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] y;
      logic [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] value;
   } res_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } stat_type;

   typedef struct packed {
      logic relabel;
      logic take;
   } cmp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_LOOK_X,
      ST_LOOK_Y,
      ST_CHECK,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

// ===== rtl/mmhs_ram.sv =====
module mmhs_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:(1 << ADDR_W)-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mmhs_cmp.sv =====
// Shared scan comparator: label match, liveness and value order for one entry.
module mmhs_cmp (
   input  logic                        is_merge,
   input  mmhs_pkg::meta_type          entry,
   input  logic [mmhs_pkg::VAL_W-1:0]  entry_value,
   input  logic [mmhs_pkg::IDX_W-1:0]  key_label,
   input  logic                        have,
   input  logic [mmhs_pkg::VAL_W-1:0]  best_value,
   output mmhs_pkg::cmp_type           result
);

   logic match;

   assign match = (entry.label == key_label);

   always_comb begin
      result.relabel = is_merge && match;
      // strict less-than keeps ties on the earlier index
      result.take    = !is_merge && match && !entry.removed &&
                       (!have || (entry_value < best_value));
   end

endmodule

// ===== rtl/mmhs_ctrl.sv =====
// Sequencer: clearing pass, load, merge relabel scan and extract-minimum scan.
module mmhs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  mmhs_pkg::cmd_type           cmd,
   output logic                        cmd_ready,
   input  logic [mmhs_pkg::CNT_W-1:0]  scan_limit,
   output logic                        res_valid,
   output mmhs_pkg::res_type           res,
   input  logic                        res_ready,
   output mmhs_pkg::stat_type          stat
);

   mmhs_pkg::state_type               state_ff, state_in;
   mmhs_pkg::cmd_type                 cmd_ff, cmd_in;
   mmhs_pkg::meta_type                rx_ff, rx_in;
   mmhs_pkg::res_type                 res_ff, res_in;
   logic [mmhs_pkg::IDX_W-1:0]        key_ff, key_in;
   logic [mmhs_pkg::IDX_W-1:0]        to_ff, to_in;
   logic [mmhs_pkg::IDX_W-1:0]        clr_ff, clr_in;
   logic [mmhs_pkg::CNT_W-1:0]        issue_ff, issue_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [mmhs_pkg::IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                              have_ff, have_in;
   logic [mmhs_pkg::IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [mmhs_pkg::VAL_W-1:0]        best_val_ff, best_val_in;

   logic                              meta_we;
   logic [mmhs_pkg::IDX_W-1:0]        meta_waddr;
   mmhs_pkg::meta_type                meta_wdata;
   mmhs_pkg::meta_type                meta_rd;
   logic [mmhs_pkg::META_W-1:0]       meta_rd_bits;
   logic                              val_we;
   logic [mmhs_pkg::IDX_W-1:0]        rd_addr;
   logic [mmhs_pkg::VAL_W-1:0]        val_rd;
   logic                              is_merge;
   logic                              issue_more;
   mmhs_pkg::cmp_type                 cmpo;

   mmhs_ram #(.WIDTH(mmhs_pkg::META_W), .ADDR_W(mmhs_pkg::IDX_W)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (rd_addr),
      .rd_data (meta_rd_bits)
   );

   assign meta_rd = mmhs_pkg::meta_type'(meta_rd_bits);

   mmhs_ram #(.WIDTH(mmhs_pkg::VAL_W), .ADDR_W(mmhs_pkg::IDX_W)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (cmd_ff.x),
      .wr_data (cmd_ff.value),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   assign is_merge   = (cmd_ff.kind == mmhs_pkg::KIND_MERGE);
   assign issue_more = (issue_ff < scan_limit);

   mmhs_cmp u_cmp (
      .is_merge    (is_merge),
      .entry       (meta_rd),
      .entry_value (val_rd),
      .key_label   (key_ff),
      .have        (have_ff),
      .best_value  (best_val_ff),
      .result      (cmpo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mmhs_pkg::ST_CLEAR;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rx_ff       <= rx_in;
      res_ff      <= res_in;
      key_ff      <= key_in;
      to_ff       <= to_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      have_ff     <= have_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rx_in         = rx_ff;
      res_in        = res_ff;
      key_in        = key_ff;
      to_in         = to_ff;
      clr_in        = clr_ff;
      issue_in      = issue_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      have_in       = have_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      meta_we       = 1'b0;
      meta_waddr    = '0;
      meta_wdata    = '0;
      val_we        = 1'b0;
      rd_addr       = '0;
      cmd_ready     = 1'b0;
      res_valid     = 1'b0;

      case (state_ff)
         mmhs_pkg::ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '{removed: 1'b0, label: clr_ff};
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = mmhs_pkg::ST_IDLE;
            end
         end
         mmhs_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               case (cmd.kind)
                  mmhs_pkg::KIND_LOAD:    state_in = mmhs_pkg::ST_LOAD;
                  mmhs_pkg::KIND_MERGE:   state_in = mmhs_pkg::ST_LOOK_X;
                  mmhs_pkg::KIND_EXTRACT: state_in = mmhs_pkg::ST_LOOK_X;
                  default:                state_in = mmhs_pkg::ST_IDLE;
               endcase
            end
         end
         mmhs_pkg::ST_LOAD: begin
            meta_we    = 1'b1;
            meta_waddr = cmd_ff.x;
            meta_wdata = '{removed: 1'b0, label: cmd_ff.x};
            val_we     = 1'b1;
            state_in   = mmhs_pkg::ST_IDLE;
         end
         mmhs_pkg::ST_LOOK_X: begin
            rd_addr  = cmd_ff.x;
            state_in = mmhs_pkg::ST_LOOK_Y;
         end
         mmhs_pkg::ST_LOOK_Y: begin
            rd_addr  = cmd_ff.y;
            rx_in    = meta_rd;
            state_in = mmhs_pkg::ST_CHECK;
         end
         mmhs_pkg::ST_CHECK: begin
            issue_in      = '0;
            pend_valid_in = 1'b0;
            have_in       = 1'b0;
            best_val_in   = '0;
            best_idx_in   = '0;
            key_in        = rx_ff.label;
            to_in         = meta_rd.label;
            if (is_merge) begin
               if (rx_ff.removed || meta_rd.removed || (rx_ff.label == meta_rd.label)) begin
                  state_in = mmhs_pkg::ST_IDLE;
               end else begin
                  state_in = mmhs_pkg::ST_SCAN;
               end
            end else if (rx_ff.removed) begin
               res_in   = '0;
               state_in = mmhs_pkg::ST_RESULT;
            end else begin
               state_in = mmhs_pkg::ST_SCAN;
            end
         end
         mmhs_pkg::ST_SCAN: begin
            // issue one read a cycle, judge the entry read the cycle before
            pend_valid_in = issue_more;
            if (issue_more) begin
               rd_addr     = issue_ff[mmhs_pkg::IDX_W-1:0];
               pend_idx_in = issue_ff[mmhs_pkg::IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
            end
            if (pend_valid_ff) begin
               if (cmpo.relabel) begin
                  meta_we    = 1'b1;
                  meta_waddr = pend_idx_ff;
                  meta_wdata = '{removed: meta_rd.removed, label: to_ff};
               end
               if (cmpo.take) begin
                  have_in     = 1'b1;
                  best_idx_in = pend_idx_ff;
                  best_val_in = val_rd;
               end
            end else if (!issue_more) begin
               if (is_merge) begin
                  state_in = mmhs_pkg::ST_IDLE;
               end else begin
                  if (have_ff) begin
                     meta_we    = 1'b1;
                     meta_waddr = best_idx_ff;
                     meta_wdata = '{removed: 1'b1, label: key_ff};
                     res_in     = '{found: 1'b1, value: best_val_ff};
                  end else begin
                     res_in = '0;
                  end
                  state_in = mmhs_pkg::ST_RESULT;
               end
            end
         end
         mmhs_pkg::ST_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = mmhs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmhs_pkg::ST_IDLE;
         end
      endcase
   end

   assign res           = res_ff;
   assign stat.clearing = (state_ff == mmhs_pkg::ST_CLEAR);
   assign stat.busy     = (state_ff != mmhs_pkg::ST_IDLE);

endmodule

// ===== rtl/mergeable_min_heap_sets_top.sv =====
// Load: written to the table, then back to idle; an unknown kind is taken and dropped.
// Merge and extract scan min(element_count, 1024) entries, one table read a cycle through
// the single comparator; no new transfer is taken until the item is finished. A merge that
// stops on a removed element or a shared set skips the scan, as does an extract of a
// removed element; an extract holds while the output register is full.
// Reset starts a clearing pass over the label/flag table; CSR writes taken always.
`include "assert_macros.svh"

module mergeable_min_heap_sets_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [55:0]                         req_tdata,  // element_index, other_index, load_value, pad
   input  logic [mmhs_pkg::KIND_W-1:0]         req_tuser,  // kind
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mmhs_pkg::VAL_W-1:0]          rsp_tdata,  // min_value
   output logic                                rsp_tuser,  // found
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mmhs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mmhs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mmhs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [mmhs_pkg::CNT_W-1:0]  elem_cnt_ff, elem_cnt_in;
   logic [mmhs_pkg::CNT_W-1:0]  scan_limit;
   logic                        csr_wr;

   mmhs_pkg::cmd_type           cmd;
   mmhs_pkg::res_type           res;
   mmhs_pkg::stat_type          stat;
   logic                        res_valid;
   logic                        res_ready;
   logic                        load_acc;

   logic                        rsp_valid_ff, rsp_valid_in;
   mmhs_pkg::res_type           rsp_ff, rsp_in;

   // Register port: zero-wait, one register at address zero
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      elem_cnt_in = elem_cnt_ff;
      if (csr_wr && (csr_paddr == mmhs_pkg::ADDR_ELEM_CNT)) begin
         elem_cnt_in = csr_pwdata[mmhs_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_cnt_ff <= mmhs_pkg::COUNT_RESET;
      end else begin
         elem_cnt_ff <= elem_cnt_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == mmhs_pkg::ADDR_ELEM_CNT) begin
         csr_prdata = mmhs_pkg::CSR_DATA_W'(elem_cnt_ff);
      end
   end

   // Clamp the scan length to the table depth
   assign scan_limit = (elem_cnt_ff > mmhs_pkg::COUNT_RESET) ? mmhs_pkg::COUNT_RESET
                                                              : elem_cnt_ff;

   // Unpack the request transfer
   always_comb begin
      cmd.kind  = req_tuser;
      cmd.x     = req_tdata[9:0];
      cmd.y     = req_tdata[19:10];
      cmd.value = req_tdata[51:20];
   end

   mmhs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_tvalid),
      .cmd        (cmd),
      .cmd_ready  (req_tready),
      .scan_limit (scan_limit),
      .res_valid  (res_valid),
      .res        (res),
      .res_ready  (res_ready),
      .stat       (stat)
   );

   // Output register: take a new result whenever the slot is empty or draining
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = rsp_ff.found;

   assign load_acc = req_tvalid && req_tready && (req_tuser == mmhs_pkg::KIND_LOAD);

   // No request is taken while the clearing pass or any item is in progress
   `ASSERT_IMPLIES(a_no_req_when_busy, clock, reset, stat.busy || stat.clearing, !req_tready)
   // A load occupies the sequencer for the following cycle
   `ASSERT_NEXT(a_load_holds, clock, reset, load_acc, !req_tready)
   // A not-found response carries a zero value
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

endmodule
